### hw/rtl/ssv_pkg.sv
// shared widths, constants, register indexes and types for the sensor sample filter
package ssv_pkg;

    localparam int TEMP_W     = 15;
    localparam int HUM_W      = 14;
    localparam int AXIS_W     = 12;
    localparam int ALPHA_W    = 16;
    localparam int FILT_W     = 14;
    localparam int STICK_W    = 7;
    localparam int CNT_W      = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic signed [TEMP_W-1:0] TEMP_MIN = -15'sd2000;
    localparam logic signed [TEMP_W-1:0] TEMP_MAX = 15'sd8000;
    localparam logic [HUM_W-1:0]         HUM_MAX  = 14'd10000;
    localparam logic signed [TEMP_W-1:0] EMA_BIAS = 15'sd2000;

    localparam logic [ALPHA_W-1:0] ALPHA_RESET    = 16'd13107;
    localparam logic [AXIS_W-1:0]  JOY_LOW_RESET  = 12'd1000;
    localparam logic [AXIS_W-1:0]  JOY_HIGH_RESET = 12'd3000;

    localparam logic [STICK_W-1:0] STICK_CENTER = 7'd0;
    localparam logic [STICK_W-1:0] STICK_X_LOW  = 7'd25;
    localparam logic [STICK_W-1:0] STICK_Y_HIGH = 7'd50;
    localparam logic [STICK_W-1:0] STICK_X_HIGH = 7'd75;
    localparam logic [STICK_W-1:0] STICK_Y_LOW  = 7'd100;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ALPHA    = 2'd0,
        CFG_JOY_LOW  = 2'd1,
        CFG_JOY_HIGH = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [AXIS_W-1:0] low;
        logic [AXIS_W-1:0] high;
    } t_stick_cfg;

endpackage

### hw/rtl/sensor_sample_validate_ema_top.sv
// top level: input register, validation, averaging state and result register
//
// Takes one sensor sample per clock and gives one result per clock while the
// receiver keeps taking results. A sample is captured in an input register,
// validated, classified and folded into the temperature and humidity averages
// in a single pass; the result is written to the output register when that
// register is empty or being read. The critical path is one multiply-add
// of the average update. A new sample is taken while a finished result
// waits, as long as the input register is free. Configuration writes are
// always taken and should be made while no sample is in flight.
module sensor_sample_validate_ema_top import ssv_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic signed [TEMP_W-1:0]   i_temp_reading,
    input  logic                       i_temp_present,
    input  logic [HUM_W-1:0]           i_hum_reading,
    input  logic                       i_hum_present,
    input  logic [AXIS_W-1:0]          i_axis_x,
    input  logic [AXIS_W-1:0]          i_axis_y,
    input  logic                       i_contact_level,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [CNT_W-1:0]           o_sequence_res,
    output logic signed [FILT_W-1:0]   o_temp_filtered,
    output logic [FILT_W-1:0]          o_hum_filtered,
    output logic [STICK_W-1:0]         o_stick_percent,
    output logic                       o_contact_closed,
    output logic                       o_anomaly,
    output logic                       o_sensor_ok,
    output logic [CNT_W-1:0]           o_rejected_total,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [CFG_DATA_W-1:0]      i_cfg_data
);

    logic [ALPHA_W-1:0]        r_alpha;
    logic [AXIS_W-1:0]         r_joy_low;
    logic [AXIS_W-1:0]         r_joy_high;

    logic                      r_in_vld;
    logic signed [TEMP_W-1:0]  r_in_temp;
    logic                      r_in_temp_pres;
    logic [HUM_W-1:0]          r_in_hum;
    logic                      r_in_hum_pres;
    logic [AXIS_W-1:0]         r_in_x;
    logic [AXIS_W-1:0]         r_in_y;
    logic                      r_in_level;

    logic                      r_out_vld;
    logic [STICK_W-1:0]        r_out_stick;
    logic                      r_out_closed;
    logic                      r_out_anomaly;
    logic                      r_out_ok;

    logic [CNT_W-1:0]          r_seq_cnt;
    logic [CNT_W-1:0]          r_rej_cnt;
    logic signed [FILT_W-1:0]  r_temp_avg;
    logic                      r_temp_seeded;
    logic [FILT_W-1:0]         r_hum_avg;
    logic                      r_hum_seeded;

    logic [CNT_W-1:0]          n_seq_cnt;
    logic [CNT_W-1:0]          n_rej_cnt;
    logic signed [FILT_W-1:0]  n_temp_avg;
    logic [FILT_W-1:0]         n_hum_avg;

    logic                      advance;
    logic                      temp_ok;
    logic                      hum_ok;
    logic                      anomaly;
    logic signed [TEMP_W-1:0]  temp_ema;
    logic signed [TEMP_W-1:0]  hum_ema;
    logic [STICK_W-1:0]        stick;
    t_stick_cfg                stick_cfg;

    assign advance     = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready  = !r_in_vld || advance;
    assign o_cfg_ready = 1'b1;

    assign temp_ok = r_in_temp_pres && (r_in_temp >= TEMP_MIN) && (r_in_temp <= TEMP_MAX);
    assign hum_ok  = r_in_hum_pres && (r_in_hum <= HUM_MAX);
    assign anomaly = !temp_ok || !hum_ok;

    assign stick_cfg.low  = r_joy_low;
    assign stick_cfg.high = r_joy_high;

    ssv_ema u_temp_ema (
        .i_alpha (r_alpha),
        .i_prev  ({r_temp_avg[FILT_W-1], r_temp_avg}),
        .i_val   (r_in_temp),
        .o_avg   (temp_ema)
    );

    ssv_ema u_hum_ema (
        .i_alpha (r_alpha),
        .i_prev  (signed'({1'b0, r_hum_avg})),
        .i_val   (signed'({1'b0, r_in_hum})),
        .o_avg   (hum_ema)
    );

    ssv_stick u_stick (
        .i_cfg     (stick_cfg),
        .i_axis_x  (r_in_x),
        .i_axis_y  (r_in_y),
        .o_percent (stick)
    );

    always_comb begin
        n_seq_cnt  = r_seq_cnt + CNT_W'(1);
        n_rej_cnt  = anomaly ? r_rej_cnt + CNT_W'(1) : r_rej_cnt;
        n_temp_avg = r_temp_avg;
        n_hum_avg  = r_hum_avg;
        if (temp_ok) begin
            n_temp_avg = r_temp_seeded ? FILT_W'(temp_ema) : FILT_W'(r_in_temp);
        end
        if (hum_ok) begin
            n_hum_avg = r_hum_seeded ? FILT_W'(hum_ema) : r_in_hum;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha    <= ALPHA_RESET;
            r_joy_low  <= JOY_LOW_RESET;
            r_joy_high <= JOY_HIGH_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ALPHA:    r_alpha    <= i_cfg_data[ALPHA_W-1:0];
                CFG_JOY_LOW:  r_joy_low  <= i_cfg_data[AXIS_W-1:0];
                CFG_JOY_HIGH: r_joy_high <= i_cfg_data[AXIS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_temp      <= i_temp_reading;
            r_in_temp_pres <= i_temp_present;
            r_in_hum       <= i_hum_reading;
            r_in_hum_pres  <= i_hum_present;
            r_in_x         <= i_axis_x;
            r_in_y         <= i_axis_y;
            r_in_level     <= i_contact_level;
        end
    end

    // filter state and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld     <= 1'b0;
            r_seq_cnt     <= '0;
            r_rej_cnt     <= '0;
            r_temp_avg    <= '0;
            r_temp_seeded <= 1'b0;
            r_hum_avg     <= '0;
            r_hum_seeded  <= 1'b0;
        end else begin
            if (advance) begin
                r_out_vld     <= 1'b1;
                r_seq_cnt     <= n_seq_cnt;
                r_rej_cnt     <= n_rej_cnt;
                r_temp_avg    <= n_temp_avg;
                r_temp_seeded <= r_temp_seeded || temp_ok;
                r_hum_avg     <= n_hum_avg;
                r_hum_seeded  <= r_hum_seeded || hum_ok;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_stick   <= stick;
            r_out_closed  <= !r_in_level;
            r_out_anomaly <= anomaly;
            r_out_ok      <= temp_ok && hum_ok;
        end
    end

    assign o_out_valid      = r_out_vld;
    assign o_sequence_res   = r_seq_cnt;
    assign o_temp_filtered  = r_temp_avg;
    assign o_hum_filtered   = r_hum_avg;
    assign o_stick_percent  = r_out_stick;
    assign o_contact_closed = r_out_closed;
    assign o_anomaly        = r_out_anomaly;
    assign o_sensor_ok      = r_out_ok;
    assign o_rejected_total = r_rej_cnt;

    a_seq_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_seq_cnt == $past(r_seq_cnt) + CNT_W'(1))
        else $error("sequence counter did not step by one");

    a_rej_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(r_rej_cnt) && $stable(r_temp_avg) && $stable(r_hum_avg))
        else $error("filter state moved without a beat");

    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_out_anomaly != r_out_ok))
        else $error("anomaly and sensor ok disagree");

    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_in_vld && r_out_vld && !i_out_ready))
        else $error("input stalled while a stage was free");

    a_hum_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hum_avg <= HUM_MAX)
        else $error("humidity average out of range");

endmodule

### hw/rtl/ssv_ema.sv
// rounded exponential moving average step with biased fixed-point terms
module ssv_ema import ssv_pkg::*; (
    input  logic [ALPHA_W-1:0]       i_alpha,
    input  logic signed [TEMP_W-1:0] i_prev,
    input  logic signed [TEMP_W-1:0] i_val,
    output logic signed [TEMP_W-1:0] o_avg
);

    localparam int SUM_W = ALPHA_W + TEMP_W + 2;
    localparam logic [SUM_W-1:0] HALF = SUM_W'(1) << (ALPHA_W - 1);

    logic [TEMP_W-1:0]          pv_b;
    logic [TEMP_W-1:0]          nv_b;
    logic [ALPHA_W:0]           w_old;
    logic [ALPHA_W+TEMP_W-1:0]  p_new;
    logic [ALPHA_W+TEMP_W:0]    p_old;
    logic [SUM_W-1:0]           sum;

    assign pv_b  = TEMP_W'(i_prev + EMA_BIAS);
    assign nv_b  = TEMP_W'(i_val + EMA_BIAS);
    assign w_old = {1'b1, {ALPHA_W{1'b0}}} - {1'b0, i_alpha};
    assign p_new = i_alpha * nv_b;
    assign p_old = w_old * pv_b;
    assign sum   = SUM_W'(p_new) + SUM_W'(p_old) + HALF;
    assign o_avg = signed'(sum[ALPHA_W +: TEMP_W]) - EMA_BIAS;

endmodule

### hw/rtl/ssv_stick.sv
// priority classifier of the two joystick axes
module ssv_stick import ssv_pkg::*; (
    input  t_stick_cfg          i_cfg,
    input  logic [AXIS_W-1:0]   i_axis_x,
    input  logic [AXIS_W-1:0]   i_axis_y,
    output logic [STICK_W-1:0]  o_percent
);

    always_comb begin
        if (i_axis_x < i_cfg.low) begin
            o_percent = STICK_X_LOW;
        end else if (i_axis_y > i_cfg.high) begin
            o_percent = STICK_Y_HIGH;
        end else if (i_axis_x > i_cfg.high) begin
            o_percent = STICK_X_HIGH;
        end else if (i_axis_y < i_cfg.low) begin
            o_percent = STICK_Y_LOW;
        end else begin
            o_percent = STICK_CENTER;
        end
    end

endmodule

### tb/sensor_sample_validate_ema_top_tb.sv
// testbench for the sensor sample filter: scoreboard check of every result against a predictor
`timescale 1ns / 1ps

module sensor_sample_validate_ema_top_tb;
    import ssv_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE_CYCLES = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temp_reading;
        logic                     temp_present;
        logic [HUM_W-1:0]         hum_reading;
        logic                     hum_present;
        logic [AXIS_W-1:0]        axis_x;
        logic [AXIS_W-1:0]        axis_y;
        logic                     contact_level;
    } t_sample;

    typedef struct packed {
        logic [CNT_W-1:0]         sequence_res;
        logic signed [FILT_W-1:0] temp_filtered;
        logic [FILT_W-1:0]        hum_filtered;
        logic [STICK_W-1:0]       stick_percent;
        logic                     contact_closed;
        logic                     anomaly;
        logic                     sensor_ok;
        logic [CNT_W-1:0]         rejected_total;
    } t_result;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_ready;
    logic signed [TEMP_W-1:0] i_temp_reading = '0;
    logic                     i_temp_present = 1'b0;
    logic [HUM_W-1:0]         i_hum_reading = '0;
    logic                     i_hum_present = 1'b0;
    logic [AXIS_W-1:0]        i_axis_x = '0;
    logic [AXIS_W-1:0]        i_axis_y = '0;
    logic                     i_contact_level = 1'b0;
    logic                     o_out_valid;
    logic                     i_out_ready = 1'b0;
    logic [CNT_W-1:0]         o_sequence_res;
    logic signed [FILT_W-1:0] o_temp_filtered;
    logic [FILT_W-1:0]        o_hum_filtered;
    logic [STICK_W-1:0]       o_stick_percent;
    logic                     o_contact_closed;
    logic                     o_anomaly;
    logic                     o_sensor_ok;
    logic [CNT_W-1:0]         o_rejected_total;
    logic                     i_cfg_valid = 1'b0;
    logic                     o_cfg_ready;
    logic [CFG_IDX_W-1:0]     i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]    i_cfg_data = '0;

    sensor_sample_validate_ema_top u_top (.*);

    always #5 i_clk = ~i_clk;

    // filter state mirrored by the predictor
    logic [ALPHA_W-1:0] alpha_q = ALPHA_RESET;
    logic [AXIS_W-1:0]  joy_low_q = JOY_LOW_RESET;
    logic [AXIS_W-1:0]  joy_high_q = JOY_HIGH_RESET;
    logic [CNT_W-1:0]   sample_count = '0;
    logic [CNT_W-1:0]   reject_count = '0;
    int                 temp_avg = 0;
    bit                 temp_seeded = 1'b0;
    int                 hum_avg = 0;
    bit                 hum_seeded = 1'b0;

    t_sample pending_samples[$];
    t_result awaited_results[$];
    t_sample held_sample;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int receiver_hold = 0;
    int hold_left = 0;
    int error_count = 0;
    int results_checked = 0;
    int anomalies_checked = 0;
    int both_valid_checked = 0;
    int reg_writes = 0;
    int cycle_count = 0;

    function automatic int ema_update(int prev, int val);
        longint w;
        longint acc;
        w = longint'(alpha_q);
        acc = w * (val + int'(EMA_BIAS)) + (65536 - w) * (prev + int'(EMA_BIAS)) + 32768;
        return int'(acc >>> 16) - int'(EMA_BIAS);
    endfunction

    function automatic t_result filter_and_classify(t_sample s);
        t_result r;
        int t;
        int h;
        bit t_ok;
        bit h_ok;
        t = int'($signed(s.temp_reading));
        h = int'(s.hum_reading);
        t_ok = s.temp_present && t >= int'(TEMP_MIN) && t <= int'(TEMP_MAX);
        h_ok = s.hum_present && h <= int'(HUM_MAX);
        sample_count = sample_count + 1;
        if (!(t_ok && h_ok)) begin
            reject_count = reject_count + 1;
        end
        if (t_ok) begin
            temp_avg = temp_seeded ? ema_update(temp_avg, t) : t;
            temp_seeded = 1'b1;
        end
        if (h_ok) begin
            hum_avg = hum_seeded ? ema_update(hum_avg, h) : h;
            hum_seeded = 1'b1;
        end
        r.sequence_res = sample_count;
        r.temp_filtered = FILT_W'(temp_seeded ? temp_avg : 0);
        r.hum_filtered = FILT_W'(hum_seeded ? hum_avg : 0);
        if (s.axis_x < joy_low_q) begin
            r.stick_percent = STICK_X_LOW;
        end else if (s.axis_y > joy_high_q) begin
            r.stick_percent = STICK_Y_HIGH;
        end else if (s.axis_x > joy_high_q) begin
            r.stick_percent = STICK_X_HIGH;
        end else if (s.axis_y < joy_low_q) begin
            r.stick_percent = STICK_Y_LOW;
        end else begin
            r.stick_percent = STICK_CENTER;
        end
        r.contact_closed = !s.contact_level;
        r.anomaly = !(t_ok && h_ok);
        r.sensor_ok = t_ok && h_ok;
        r.rejected_total = reject_count;
        return r;
    endfunction

    function automatic string show(t_result r);
        return $sformatf("seq=%0d temp=%0d hum=%0d stick=%0d closed=%0b anomaly=%0b ok=%0b rej=%0d",
                         r.sequence_res, $signed(r.temp_filtered), r.hum_filtered,
                         r.stick_percent, r.contact_closed, r.anomaly, r.sensor_ok,
                         r.rejected_total);
    endfunction

    // sample driver
    always @(posedge i_clk) begin : drive_samples
        logic next_valid;
        t_sample s;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            next_valid = i_in_valid;
            if (i_in_valid && o_in_ready) begin
                awaited_results.push_back(filter_and_classify(held_sample));
                next_valid = 1'b0;
            end
            if (!next_valid && pending_samples.size() != 0 &&
                $urandom_range(99) >= send_idle_pct) begin
                s = pending_samples.pop_front();
                held_sample = s;
                i_temp_reading <= s.temp_reading;
                i_temp_present <= s.temp_present;
                i_hum_reading <= s.hum_reading;
                i_hum_present <= s.hum_present;
                i_axis_x <= s.axis_x;
                i_axis_y <= s.axis_y;
                i_contact_level <= s.contact_level;
                next_valid = 1'b1;
            end
            i_in_valid <= next_valid;
        end
    end

    // result monitor and scoreboard
    always @(posedge i_clk) begin : check_results
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                got = {o_sequence_res, o_temp_filtered, o_hum_filtered, o_stick_percent,
                       o_contact_closed, o_anomaly, o_sensor_ok, o_rejected_total};
                if (awaited_results.size() == 0) begin
                    if (error_count < 10) begin
                        $display("unexpected result beat: %s", show(got));
                    end
                    error_count++;
                end else begin
                    want = awaited_results.pop_front();
                    results_checked++;
                    anomalies_checked += want.anomaly;
                    both_valid_checked += want.sensor_ok;
                    if (got !== want) begin
                        if (error_count < 10) begin
                            $display("mismatch\n  expected %s\n  actual   %s",
                                     show(want), show(got));
                        end
                        error_count++;
                    end
                end
            end
            if (receiver_hold != 0) begin
                hold_left = receiver_hold;
                receiver_hold = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, awaited_results.size());
            $display("tb: failure");
            $finish;
        end
    end

    task automatic settle();
        do @(negedge i_clk);
        while (pending_samples.size() != 0 || i_in_valid || awaited_results.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        case (idx)
            CFG_ALPHA:    alpha_q = data;
            CFG_JOY_LOW:  joy_low_q = data[AXIS_W-1:0];
            CFG_JOY_HIGH: joy_high_q = data[AXIS_W-1:0];
            default: ;
        endcase
        reg_writes++;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_filter(int a, int lo, int hi);
        settle();
        write_reg(CFG_ALPHA, ALPHA_W'(a));
        write_reg(CFG_JOY_LOW, {4'($urandom_range(15)), AXIS_W'(lo)});
        write_reg(CFG_JOY_HIGH, {4'($urandom_range(15)), AXIS_W'(hi)});
    endtask

    function automatic void push_sample(int t, bit tp, int h, bit hp, int x, int y, bit lvl);
        t_sample s;
        s.temp_reading = TEMP_W'(t);
        s.temp_present = tp;
        s.hum_reading = HUM_W'(h);
        s.hum_present = hp;
        s.axis_x = AXIS_W'(x);
        s.axis_y = AXIS_W'(y);
        s.contact_level = lvl;
        pending_samples.push_back(s);
    endfunction

    function automatic int near_threshold_axis();
        int thr;
        if ($urandom_range(3) != 0) begin
            return int'($urandom_range(4095));
        end
        thr = $urandom_range(1) ? int'(joy_low_q) : int'(joy_high_q);
        return thr + int'($urandom_range(2)) - 1;
    endfunction

    function automatic void push_random_sample();
        int temp_edges[6] = '{-2001, -2000, -1999, 7999, 8000, 8001};
        int hum_edges[6] = '{0, 1, 9999, 10000, 10001, 16383};
        int t;
        int h;
        case ($urandom_range(9))
            0: t = int'($urandom_range(32767)) - 16384;
            1: t = temp_edges[$urandom_range(5)];
            default: t = int'($urandom_range(10000)) - 2000;
        endcase
        case ($urandom_range(9))
            0: h = $urandom_range(16383);
            1: h = hum_edges[$urandom_range(5)];
            default: h = $urandom_range(10000);
        endcase
        push_sample(t, $urandom_range(99) < 90, h, $urandom_range(99) < 90,
                    near_threshold_axis(), near_threshold_axis(), $urandom_range(1));
    endfunction

    initial begin : stimulus
        int a;
        int lo;
        int hi;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: unseeded outputs, range edges, every stick class and its priority
        push_sample(0, 0, 0, 0, 2048, 2048, 1);
        push_sample(16383, 1, 16383, 1, 0, 2048, 0);
        push_sample(-16384, 1, 10001, 1, 2048, 4095, 1);
        push_sample(-2001, 1, 5000, 0, 4095, 2048, 0);
        push_sample(8001, 1, 12000, 1, 2048, 0, 1);
        push_sample(-2000, 1, 0, 1, 1000, 3000, 0);
        push_sample(8000, 1, 10000, 1, 999, 3001, 1);
        push_sample(8000, 1, 10000, 1, 3001, 3001, 0);
        push_sample(2500, 0, 10000, 1, 3001, 999, 1);
        push_sample(2500, 1, 20, 0, 1000, 999, 0);
        push_sample(-2000, 1, 0, 1, 3000, 1000, 1);
        push_sample(8000, 1, 10000, 1, 4095, 4095, 0);

        // frozen averages, low threshold above high, write to a missing register
        set_filter(0, 4095, 0);
        write_reg(CFG_UNUSED, 16'hFFFF);
        push_sample(5000, 1, 5000, 1, 4095, 0, 1);
        push_sample(-2000, 1, 10000, 1, 100, 100, 0);
        push_sample(8000, 1, 0, 1, 4095, 1, 1);

        set_filter(65535, 0, 4095);
        push_sample(1234, 1, 4321, 1, 0, 0, 0);
        push_sample(-1999, 1, 9999, 1, 4095, 4095, 1);
        push_sample(7999, 1, 1, 1, 2048, 2048, 0);

        set_filter(1, 2048, 2048);
        push_sample(8000, 1, 10000, 1, 2048, 2048, 1);
        push_sample(8000, 1, 10000, 1, 2049, 2047, 0);
        push_sample(-2000, 1, 0, 1, 2048, 2047, 1);

        for (int p = 0; p < 8; p++) begin
            case ($urandom_range(3))
                0: a = 65535;
                1: a = $urandom_range(255);
                default: a = $urandom_range(65535);
            endcase
            if ($urandom_range(2) == 0) begin
                lo = $urandom_range(4095);
                hi = $urandom_range(4095);
            end else begin
                lo = $urandom_range(1500, 500);
                hi = $urandom_range(3500, 2500);
            end
            set_filter(a, lo, hi);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
                default: begin send_idle_pct = 9; recv_stall_pct = 9; end
            endcase
            repeat (105) push_random_sample();

            // back up the output while samples keep coming
            if (p == 4) begin
                settle();
                send_idle_pct = 0;
                recv_stall_pct = 0;
                receiver_hold = 300;
                repeat (60) push_random_sample();
            end
        end

        settle();
        if (awaited_results.size() != 0) begin
            error_count++;
        end
        $display("checked %0d results: %0d with a rejected reading, %0d with both valid",
                 results_checked, anomalies_checked, both_valid_checked);
        $display("%0d register writes across directed and random filter settings, %0d errors",
                 reg_writes, error_count);
        if (error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
